@@ src/bm3_pkg.sv @@
package bm3_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W = 2;

  typedef logic [PIX_W-1:0] pix_t;

  // One window column: index 0 is the top row, index 2 the bottom row.
  typedef pix_t [2:0] bm3_col_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_OP_SELECT    = 2'd2
  } reg_idx_t;

  localparam logic OP_DILATE = 1'b0;
  localparam logic OP_ERODE  = 1'b1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  localparam pix_t PIX_WHITE = 8'hFF;
  localparam pix_t PIX_BLACK = 8'h00;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd64;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd64;

  // Which neighbors of the window center lie inside the frame.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } bm3_mask_t;

endpackage

@@ src/binary_morphology_3x3.sv @@
// Channel  | Direction | Signals                                   | Content
// in       | input     | in_tvalid, in_tready, in_tdata, in_tuser  | pixel, flush flag
// out      | output    | out_tvalid, out_tready, out_tdata, out_tlast | result, frame end
// cfg      | input     | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes
//
// One input transfer per clock is sustained while out_tready is high; a result leaves
// after its window completes, via line store read, window shift and output register.
// Both line buffers share one dual-port RAM of MAX_WIDTH words, which allows that rate.
// Reset clears the position counters and pipeline valids and loads the register defaults.
// When out_tready is low the pipeline holds and in_tready drops once it is full.
module binary_morphology_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] pixel
  input  logic                               in_tuser,   // [0] mode
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // [7:0] pixel_out
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bm3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bm3_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int PW = bm3_pkg::PIX_W;
  localparam int LW = 2 * PW;

  function automatic logic [WW-1:0] eff_width(input logic [bm3_pkg::CFG_DATA_W-1:0] v);
    if (v == '0) begin
      return WW'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      return WW'(MAX_WIDTH);
    end
    return WW'(v);
  endfunction

  function automatic logic [HW-1:0] eff_height(input logic [bm3_pkg::CFG_DATA_W-1:0] v);
    if (v == '0) begin
      return HW'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      return HW'(MAX_HEIGHT);
    end
    return HW'(v);
  endfunction

  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic          op_r;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic              s1_v_r;
  logic              s1_prod_r;
  logic              s1_eof_r;
  bm3_pkg::pix_t     s1_val_r;
  bm3_pkg::bm3_mask_t s1_mask_r;
  logic [CW-1:0]     s1_addr_r;
  logic              byp_r;
  logic [LW-1:0]     byp_word_r;

  logic               s2_v_r;
  logic               s2_eof_r;
  bm3_pkg::bm3_mask_t s2_mask_r;

  logic          out_v_r;
  bm3_pkg::pix_t out_pix_r;
  logic          out_last_r;

  logic in_fire, cfg_fire, out_free, s2_go, s1_go;

  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;
  logic [CW-1:0] qc;
  logic [RW-1:0] qr;
  logic          produce, eof;
  bm3_pkg::bm3_mask_t mask;
  bm3_pkg::pix_t      val;

  logic [LW-1:0] ram_rdata;
  logic [LW-1:0] line_word;
  logic [LW-1:0] wr_word;

  bm3_pkg::bm3_col_t       new_col;
  bm3_pkg::bm3_col_t [3:0] chain;
  logic [2:0]              cell_hit;
  logic [2:0]              row_en;
  logic [2:0]              col_en;
  bm3_pkg::pix_t           target;
  bm3_pkg::pix_t           result;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign out_free  = !out_v_r || out_tready;
  assign s2_go     = !s2_v_r || out_free;
  assign s1_go     = s1_v_r && s2_go;
  assign in_tready = !s1_v_r || s2_go;
  assign in_fire   = in_tvalid && in_tready;

  // Position of the window center for the item now arriving.
  always_comb begin
    wm1 = CW'(width_r - WW'(1));
    hm1 = RW'(height_r - HW'(1));
    if (col_r == '0) begin
      qc = wm1;
      qr = row_r - RW'(2);
    end else begin
      qc = col_r - CW'(1);
      qr = row_r - RW'(1);
    end
    produce     = (row_r > RW'(1)) || ((row_r == RW'(1)) && (col_r != '0));
    eof         = produce && (qr == hm1) && (qc == wm1);
    mask.top    = (qr != '0);
    mask.bottom = (qr != hm1);
    mask.left   = (qc != '0);
    mask.right  = (qc != wm1);
    if ((in_tuser == bm3_pkg::MODE_FLUSH) || (row_r >= RW'(height_r))) begin
      val = bm3_pkg::PIX_BLACK;
    end else begin
      val = in_tdata;
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (eof) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r == wm1) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= eff_width(bm3_pkg::FRAME_WIDTH_RST);
      height_r <= eff_height(bm3_pkg::FRAME_HEIGHT_RST);
      op_r     <= bm3_pkg::OP_DILATE;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        bm3_pkg::REG_FRAME_WIDTH: begin
          width_r <= eff_width(cfg_data);
          col_r   <= '0;
          row_r   <= '0;
        end
        bm3_pkg::REG_FRAME_HEIGHT: begin
          height_r <= eff_height(cfg_data);
          col_r    <= '0;
          row_r    <= '0;
        end
        bm3_pkg::REG_OP_SELECT: begin
          op_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Each RAM word holds the two previous rows at one column: upper half two rows back.
  assign line_word = byp_r ? byp_word_r : ram_rdata;
  assign wr_word   = {line_word[PW-1:0], s1_val_r};

  bm3_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (s1_go),
    .waddr(s1_addr_r),
    .wdata(wr_word),
    .re   (in_fire),
    .raddr(col_r),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_prod_r  <= produce;
      s1_eof_r   <= eof;
      s1_val_r   <= val;
      s1_mask_r  <= mask;
      s1_addr_r  <= col_r;
      byp_r      <= s1_go && (s1_addr_r == col_r);
      byp_word_r <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_go) begin
      s2_v_r <= s1_v_r && s1_prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_eof_r  <= s1_eof_r;
      s2_mask_r <= s1_mask_r;
    end
  end

  assign new_col[0] = line_word[LW-1:PW];
  assign new_col[1] = line_word[PW-1:0];
  assign new_col[2] = s1_val_r;
  assign chain[0]   = new_col;

  assign row_en = {s2_mask_r.bottom, 1'b1, s2_mask_r.top};
  assign col_en = {s2_mask_r.left, 1'b1, s2_mask_r.right};
  assign target = (op_r == bm3_pkg::OP_ERODE) ? bm3_pkg::PIX_BLACK : bm3_pkg::PIX_WHITE;

  for (genvar k = 0; k < 3; k++) begin : g_cell
    bm3_cell u_cell (
      .clk    (clk),
      .shift  (s1_go),
      .col_in (chain[k]),
      .row_en (row_en),
      .col_en (col_en[k]),
      .target (target),
      .col_out(chain[k+1]),
      .hit    (cell_hit[k])
    );
  end

  assign result = (cell_hit != 3'b000) ? target : chain[2][1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_v_r) begin
      out_pix_r  <= result;
      out_last_r <= s2_eof_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule

@@ src/bm3_ram.sv @@
module bm3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/bm3_cell.sv @@
module bm3_cell (
  input  logic              clk,
  input  logic              shift,
  input  bm3_pkg::bm3_col_t col_in,
  input  logic [2:0]        row_en,
  input  logic              col_en,
  input  bm3_pkg::pix_t     target,
  output bm3_pkg::bm3_col_t col_out,
  output logic              hit
);

  bm3_pkg::bm3_col_t col_r;
  logic [2:0]        match;

  always_ff @(posedge clk) begin
    if (shift) begin
      col_r <= col_in;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      match[i] = row_en[i] && (col_r[i] == target);
    end
  end

  assign hit     = col_en && (match != 3'b000);
  assign col_out = col_r;

endmodule
